// ===== rtl/wpp_pkg.sv =====
package wpp_pkg;

  // Longest path that the position counter tracks before it saturates
  localparam int MAX_PATH_CHARS = 4095;
  localparam int POS_W          = $clog2(MAX_PATH_CHARS + 1);

  // Field widths of the channels
  localparam int CH_W  = 16;
  localparam int PL_W  = 12;
  localparam int PK_W  = 3;

  // Depth of the queue between classifier and parser
  localparam int QDEPTH = 2;

  // Character codes that matter to the prefix grammar
  localparam logic [CH_W-1:0] CH_ZERO   = 16'h0000;
  localparam logic [CH_W-1:0] CH_BSLASH = 16'h005C;
  localparam logic [CH_W-1:0] CH_COLON  = 16'h003A;
  localparam logic [CH_W-1:0] CH_DOT    = 16'h002E;
  localparam logic [CH_W-1:0] CH_QMARK  = 16'h003F;
  localparam logic [CH_W-1:0] CH_U      = 16'h0055;
  localparam logic [CH_W-1:0] CH_N      = 16'h004E;
  localparam logic [CH_W-1:0] CH_C      = 16'h0043;
  localparam logic [CH_W-1:0] CH_UA     = 16'h0041;
  localparam logic [CH_W-1:0] CH_UZ     = 16'h005A;
  localparam logic [CH_W-1:0] CH_LA     = 16'h0061;
  localparam logic [CH_W-1:0] CH_LZ     = 16'h007A;

  // Character class as seen by the parser
  typedef enum logic [3:0] {
    CL_ZERO   = 4'd0,
    CL_BSLASH = 4'd1,
    CL_COLON  = 4'd2,
    CL_DOT    = 4'd3,
    CL_QMARK  = 4'd4,
    CL_U      = 4'd5,
    CL_N      = 4'd6,
    CL_C      = 4'd7,
    CL_LETTER = 4'd8,
    CL_OTHER  = 4'd9
  } cls_t;

  // Prefix kinds reported on the result channel
  typedef enum logic [PK_W-1:0] {
    K_NONE   = 3'd0,
    K_DRIVE  = 3'd1,
    K_DEVICE = 3'd2,
    K_VERB   = 3'd3,
    K_VDRIVE = 3'd4,
    K_VUNC   = 3'd5,
    K_UNC    = 3'd6
  } kind_t;

  // One queued character
  typedef struct packed {
    cls_t cls;
    logic last;
  } entry_t;

endpackage

// ===== rtl/wpp_if.sv =====
interface wpp_in_if;
  import wpp_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface wpp_out_if;
  import wpp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PK_W-1:0] prefix_kind;
  logic [PL_W-1:0] prefix_len;
  logic            rooted;
  logic            absolute;
  logic            overflow;

  modport source (output valid, output prefix_kind, output prefix_len, output rooted,
                  output absolute, output overflow, input ready);
  modport sink   (input valid, input prefix_kind, input prefix_len, input rooted,
                  input absolute, input overflow, output ready);
endinterface

// ===== rtl/wpp_front.sv =====
module wpp_front
  import wpp_pkg::*;
(
  wpp_in_if.sink   in_chan,
  output logic     wr_valid,
  output entry_t   wr_data,
  input  logic     wr_ready
);

  // Map a code unit onto the classes the grammar distinguishes
  function automatic cls_t classify(input logic [CH_W-1:0] c);
    cls_t r;
    if (c == CH_ZERO)                              r = CL_ZERO;
    else if (c == CH_BSLASH)                       r = CL_BSLASH;
    else if (c == CH_COLON)                        r = CL_COLON;
    else if (c == CH_DOT)                          r = CL_DOT;
    else if (c == CH_QMARK)                        r = CL_QMARK;
    else if (c == CH_U)                            r = CL_U;
    else if (c == CH_N)                            r = CL_N;
    else if (c == CH_C)                            r = CL_C;
    else if ((c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ))
                                                   r = CL_LETTER;
    else                                           r = CL_OTHER;
    return r;
  endfunction

  // Push classified characters into the queue while it has room
  assign in_chan.ready = wr_ready;
  assign wr_valid      = in_chan.valid;
  assign wr_data.cls   = classify(in_chan.ch);
  assign wr_data.last  = in_chan.last;

endmodule

// ===== rtl/wpp_fifo.sv =====
module wpp_fifo
  import wpp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  entry_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output entry_t rd_data
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  entry_t           slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_FULL);
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/wpp_back.sv =====
module wpp_back
  import wpp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_valid,
  output logic       rd_ready,
  input  entry_t     rd_data,
  wpp_out_if.source  out_chan
);

  localparam int PH_W = 22;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PATH_CHARS);

  typedef enum logic [PH_W-1:0] {
    PH_START = PH_W'(1) << 0,
    PH_L1    = PH_W'(1) << 1,
    PH_DRV2  = PH_W'(1) << 2,
    PH_S1    = PH_W'(1) << 3,
    PH_S2    = PH_W'(1) << 4,
    PH_DOT   = PH_W'(1) << 5,
    PH_Q     = PH_W'(1) << 6,
    PH_DEV0  = PH_W'(1) << 7,
    PH_DEV   = PH_W'(1) << 8,
    PH_VERB0 = PH_W'(1) << 9,
    PH_VL    = PH_W'(1) << 10,
    PH_VU    = PH_W'(1) << 11,
    PH_VUN   = PH_W'(1) << 12,
    PH_VUNC  = PH_W'(1) << 13,
    PH_VSRV0 = PH_W'(1) << 14,
    PH_VSRV  = PH_W'(1) << 15,
    PH_VSH0  = PH_W'(1) << 16,
    PH_VSH   = PH_W'(1) << 17,
    PH_USRV  = PH_W'(1) << 18,
    PH_USH0  = PH_W'(1) << 19,
    PH_USH   = PH_W'(1) << 20,
    PH_DONE  = PH_W'(1) << 21
  } phase_t;

  typedef struct packed {
    phase_t           phase;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] hlen;
    kind_t            kind;
    logic             root;
    logic             ended;
    logic             sat;
  } pstate_t;

  localparam pstate_t ST_RESET = '{phase: PH_START, pos: '0, hlen: '0, kind: K_NONE,
                                   root: 1'b0, ended: 1'b0, sat: 1'b0};

  // Settle the prefix and stop parsing
  function automatic pstate_t decide(input pstate_t s, input kind_t k,
                                     input logic [POS_W-1:0] len);
    pstate_t r;
    r       = s;
    r.kind  = k;
    r.hlen  = len;
    r.phase = PH_DONE;
    return r;
  endfunction

  // One grammar step on a character class, ahead of the position update
  function automatic pstate_t advance(input pstate_t s, input cls_t c);
    pstate_t r;
    logic    letter;
    logic    eos;
    r      = s;
    letter = (c == CL_LETTER) || (c == CL_U) || (c == CL_N) || (c == CL_C);
    eos    = (c == CL_ZERO) || (c == CL_BSLASH);
    case (s.phase)
      PH_START: begin
        if (letter) r.phase = PH_L1;
        else if (c == CL_BSLASH) begin
          r.root  = 1'b1;
          r.phase = PH_S1;
        end else r = decide(s, K_NONE, '0);
      end
      PH_L1: begin
        if (c == CL_COLON) begin
          r.kind  = K_DRIVE;
          r.hlen  = POS_W'(2);
          r.phase = PH_DRV2;
        end else r = decide(s, K_NONE, '0);
      end
      PH_DRV2: begin
        if (c == CL_BSLASH) r.root = 1'b1;
        r.phase = PH_DONE;
      end
      PH_S1: begin
        if (c == CL_BSLASH) r.phase = PH_S2;
        else r = decide(s, K_NONE, '0);
      end
      PH_S2: begin
        if (c == CL_DOT) r.phase = PH_DOT;
        else if (c == CL_QMARK) r.phase = PH_Q;
        else if (eos) r = decide(s, K_NONE, '0);
        else r.phase = PH_USRV;
      end
      PH_DOT: begin
        if (c == CL_BSLASH) r.phase = PH_DEV0;
        else if (c == CL_ZERO) r = decide(s, K_NONE, '0);
        else r.phase = PH_USRV;
      end
      PH_Q: begin
        if (c == CL_BSLASH) r.phase = PH_VERB0;
        else if (c == CL_ZERO) r = decide(s, K_NONE, '0);
        else r.phase = PH_USRV;
      end
      PH_DEV0: begin
        if (eos) r = decide(s, K_NONE, '0);
        else r.phase = PH_DEV;
      end
      PH_DEV: begin
        if (eos) r = decide(s, K_DEVICE, s.pos);
      end
      PH_VERB0: begin
        if (c == CL_U) r.phase = PH_VU;
        else if (letter) r.phase = PH_VL;
        else r = decide(s, K_VERB, POS_W'(4));
      end
      PH_VL: begin
        if (c == CL_COLON) r = decide(s, K_VDRIVE, POS_W'(6));
        else r = decide(s, K_VERB, POS_W'(4));
      end
      PH_VU: begin
        if (c == CL_COLON) r = decide(s, K_VDRIVE, POS_W'(6));
        else if (c == CL_N) r.phase = PH_VUN;
        else r = decide(s, K_VERB, POS_W'(4));
      end
      PH_VUN: begin
        if (c == CL_C) r.phase = PH_VUNC;
        else r = decide(s, K_VERB, POS_W'(4));
      end
      PH_VUNC: begin
        if (c == CL_BSLASH) r.phase = PH_VSRV0;
        else r = decide(s, K_VERB, POS_W'(4));
      end
      PH_VSRV0: begin
        if (eos) r = decide(s, K_NONE, '0);
        else r.phase = PH_VSRV;
      end
      PH_VSRV: begin
        if (c == CL_ZERO) r = decide(s, K_NONE, '0);
        else if (c == CL_BSLASH) r.phase = PH_VSH0;
      end
      PH_VSH0: begin
        if (eos) r = decide(s, K_NONE, '0);
        else r.phase = PH_VSH;
      end
      PH_VSH: begin
        if (eos) r = decide(s, K_VUNC, s.pos);
      end
      PH_USRV: begin
        if (c == CL_ZERO) r = decide(s, K_NONE, '0);
        else if (c == CL_BSLASH) r.phase = PH_USH0;
      end
      PH_USH0: begin
        if (eos) r = decide(s, K_NONE, '0);
        else r.phase = PH_USH;
      end
      PH_USH: begin
        if (eos) r = decide(s, K_UNC, s.pos);
      end
      default: r.phase = PH_DONE;
    endcase
    return r;
  endfunction

  // Full character step: grammar, terminator latch, saturating position
  function automatic pstate_t feed(input pstate_t s, input cls_t c);
    pstate_t r;
    r = s;
    if (!s.ended) begin
      r = advance(s, c);
      if (c == CL_ZERO) begin
        r.ended = 1'b1;
        r.phase = PH_DONE;
      end else if (s.pos >= POS_MAX) begin
        r.sat = 1'b1;
      end else begin
        r.pos = s.pos + POS_W'(1);
      end
    end
    return r;
  endfunction

  pstate_t                st_r, st_nxt;
  pstate_t                s1, s2;
  logic                   out_valid_r, out_valid_nxt;
  logic [PK_W-1:0]        kind_r;
  logic [PL_W-1:0]        len_r;
  logic                   rooted_r, absolute_r, overflow_r;
  logic                   out_free, pop, emit;
  logic [PL_W+POS_W-1:0]  len_ext;

  assign out_free = !out_valid_r || out_chan.ready;
  assign rd_ready = !rd_data.last || out_free;
  assign pop      = rd_valid && rd_ready;
  assign emit     = pop && rd_data.last;

  // Step on the queued character, then once more on the implied terminator
  assign s1      = feed(st_r, rd_data.cls);
  assign s2      = feed(s1, CL_ZERO);
  assign len_ext = {{PL_W{1'b0}}, s2.hlen};

  always_comb begin
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (out_chan.ready) out_valid_nxt = 1'b0;
    if (pop) begin
      st_nxt = emit ? ST_RESET : s1;
    end
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result register when a path closes
  always_ff @(posedge clk) begin
    if (emit) begin
      kind_r     <= s2.kind;
      len_r      <= len_ext[PL_W-1:0];
      rooted_r   <= s2.root;
      absolute_r <= (s2.hlen != '0) && s2.root;
      overflow_r <= s2.sat;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.prefix_kind = kind_r;
  assign out_chan.prefix_len  = len_r;
  assign out_chan.rooted      = rooted_r;
  assign out_chan.absolute    = absolute_r;
  assign out_chan.overflow    = overflow_r;

endmodule

// ===== rtl/windows_path_prefix_parser.sv =====
// Channel    Dir  Payload                                          Handshake
// in_chan    in   ch[15:0], last                                   valid/ready
// out_chan   out  prefix_kind[2:0], prefix_len[11:0], rooted,      valid/ready
//                 absolute, overflow
//
// Takes one character per cycle while the queue has room; the parser steps once per
// dequeued character. A result goes valid when its last character leaves the queue.
// Synchronous active-low reset clears the queue, the parser and the result valid.
// A stalled result blocks only a queued last character; other characters keep
// flowing, and the input stalls once the two-entry queue is full.
module windows_path_prefix_parser
  import wpp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  wpp_in_if.sink    in_chan,
  wpp_out_if.source out_chan
);

  logic   wr_valid, wr_ready;
  entry_t wr_data;
  logic   rd_valid, rd_ready;
  entry_t rd_data;

  wpp_front u_front (
    .in_chan  (in_chan),
    .wr_valid (wr_valid),
    .wr_data  (wr_data),
    .wr_ready (wr_ready)
  );

  wpp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  wpp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data),
    .out_chan (out_chan)
  );

endmodule

// ===== rtl/wpp_checker.sv =====
module wpp_checker
  import wpp_pkg::*;
(
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input logic [PK_W-1:0] prefix_kind,
  input logic [PL_W-1:0] prefix_len,
  input logic            rooted,
  input logic            absolute,
  input logic            overflow
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(prefix_kind) && $stable(prefix_len)
      && $stable(rooted) && $stable(absolute) && $stable(overflow))
    else $error("stalled result changed");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Absolute needs a root and a recognized prefix
  a_absolute: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && absolute |-> rooted && (prefix_kind != K_NONE))
    else $error("absolute without root or prefix");

  // No prefix means zero length
  a_none_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (prefix_kind == K_NONE) |-> (prefix_len == '0) && !absolute)
    else $error("empty prefix with nonzero length");

  // Drive prefix is always two characters
  a_drive_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (prefix_kind == K_DRIVE) |-> (prefix_len == PL_W'(2)))
    else $error("drive prefix length wrong");

endmodule

bind windows_path_prefix_parser wpp_checker u_wpp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .prefix_kind (out_chan.prefix_kind),
  .prefix_len  (out_chan.prefix_len),
  .rooted      (out_chan.rooted),
  .absolute    (out_chan.absolute),
  .overflow    (out_chan.overflow)
);

// ===== sim/windows_path_prefix_parser_test.sv =====
module windows_path_prefix_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wpp_pkg::*;

  localparam int unsigned RANDOM_CHARS = 1400;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT  = 5000;

  typedef logic [CH_W-1:0] char_q_t[$];

  // Parser phases of the prefix grammar
  typedef enum logic [4:0] {
    P_START, P_LETTER, P_DRIVE, P_SEP1, P_SEP2, P_DOT, P_QMARK,
    P_DEV_FIRST, P_DEV_NAME, P_VERB_FIRST, P_VERB_LETTER, P_VERB_U, P_VERB_UN,
    P_VERB_UNC, P_VSRV_FIRST, P_VSRV, P_VSHARE_FIRST, P_VSHARE,
    P_SRV, P_SHARE_FIRST, P_SHARE, P_DONE
  } parse_phase_t;

  typedef struct {
    parse_phase_t    phase;
    logic [PL_W-1:0] pos;
    logic [PL_W-1:0] plen;
    kind_t           kind;
    logic            rooted;
    logic            ended;
    logic            saturated;
  } path_scan_t;

  typedef struct packed {
    kind_t           kind;
    logic [PL_W-1:0] len;
    logic            rooted;
    logic            absolute;
    logic            overflow;
  } prefix_result_t;

  logic clk = 1'b0;
  logic rst_n;

  wpp_in_if  in_if();
  wpp_out_if out_if();

  windows_path_prefix_parser u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always #5 clk = ~clk;

  path_scan_t     scan;
  prefix_result_t pending_prefixes[$];
  int unsigned    fail_count    = 0;
  int unsigned    chars_sent    = 0;
  int unsigned    stall_cycles  = 0;
  bit             idle_enabled  = 1'b1;
  bit             long_hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // Prefix predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_letter(logic [CH_W-1:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ);
  endfunction

  function automatic void clear_scan();
    scan.phase     = P_START;
    scan.pos       = '0;
    scan.plen      = '0;
    scan.kind      = K_NONE;
    scan.rooted    = 1'b0;
    scan.ended     = 1'b0;
    scan.saturated = 1'b0;
  endfunction

  function automatic void settle(kind_t k, logic [PL_W-1:0] len);
    scan.kind  = k;
    scan.plen  = len;
    scan.phase = P_DONE;
  endfunction

  // Close a server or share name on the terminator or a separator
  function automatic void close_name(logic [CH_W-1:0] c, parse_phase_t on_sep, kind_t k);
    if (c == CH_ZERO) begin
      settle(k, (k == K_NONE) ? '0 : scan.pos);
    end else if (c == CH_BSLASH) begin
      if (k == K_NONE) scan.phase = on_sep;
      else settle(k, scan.pos);
    end
  endfunction

  function automatic void step_phase(logic [CH_W-1:0] c);
    logic stop;
    stop = (c == CH_ZERO) || (c == CH_BSLASH);
    case (scan.phase)
      P_START: begin
        if (is_letter(c)) scan.phase = P_LETTER;
        else if (c == CH_BSLASH) begin
          scan.rooted = 1'b1;
          scan.phase  = P_SEP1;
        end else settle(K_NONE, '0);
      end
      P_LETTER: begin
        if (c == CH_COLON) begin
          scan.kind  = K_DRIVE;
          scan.plen  = 2;
          scan.phase = P_DRIVE;
        end else settle(K_NONE, '0);
      end
      P_DRIVE: begin
        if (c == CH_BSLASH) scan.rooted = 1'b1;
        scan.phase = P_DONE;
      end
      P_SEP1: begin
        if (c == CH_BSLASH) scan.phase = P_SEP2;
        else settle(K_NONE, '0);
      end
      P_SEP2: begin
        if (c == CH_DOT) scan.phase = P_DOT;
        else if (c == CH_QMARK) scan.phase = P_QMARK;
        else if (stop) settle(K_NONE, '0);
        else scan.phase = P_SRV;
      end
      P_DOT: begin
        if (c == CH_BSLASH) scan.phase = P_DEV_FIRST;
        else if (c == CH_ZERO) settle(K_NONE, '0);
        else scan.phase = P_SRV;
      end
      P_QMARK: begin
        if (c == CH_BSLASH) scan.phase = P_VERB_FIRST;
        else if (c == CH_ZERO) settle(K_NONE, '0);
        else scan.phase = P_SRV;
      end
      P_DEV_FIRST: begin
        if (stop) settle(K_NONE, '0);
        else scan.phase = P_DEV_NAME;
      end
      P_DEV_NAME: begin
        if (stop) settle(K_DEVICE, scan.pos);
      end
      P_VERB_FIRST: begin
        if (c == CH_U) scan.phase = P_VERB_U;
        else if (is_letter(c)) scan.phase = P_VERB_LETTER;
        else settle(K_VERB, 4);
      end
      P_VERB_LETTER: begin
        if (c == CH_COLON) settle(K_VDRIVE, 6);
        else settle(K_VERB, 4);
      end
      P_VERB_U: begin
        if (c == CH_COLON) settle(K_VDRIVE, 6);
        else if (c == CH_N) scan.phase = P_VERB_UN;
        else settle(K_VERB, 4);
      end
      P_VERB_UN: begin
        if (c == CH_C) scan.phase = P_VERB_UNC;
        else settle(K_VERB, 4);
      end
      P_VERB_UNC: begin
        if (c == CH_BSLASH) scan.phase = P_VSRV_FIRST;
        else settle(K_VERB, 4);
      end
      P_VSRV_FIRST: begin
        if (stop) settle(K_NONE, '0);
        else scan.phase = P_VSRV;
      end
      P_VSRV: close_name(c, P_VSHARE_FIRST, K_NONE);
      P_VSHARE_FIRST: begin
        if (stop) settle(K_NONE, '0);
        else scan.phase = P_VSHARE;
      end
      P_VSHARE: close_name(c, P_DONE, K_VUNC);
      P_SRV: close_name(c, P_SHARE_FIRST, K_NONE);
      P_SHARE_FIRST: begin
        if (stop) settle(K_NONE, '0);
        else scan.phase = P_SHARE;
      end
      P_SHARE: close_name(c, P_DONE, K_UNC);
      default: scan.phase = P_DONE;
    endcase
  endfunction

  // Advance on one code unit; units after the terminator are dropped
  function automatic void scan_char(logic [CH_W-1:0] c);
    if (scan.ended) return;
    step_phase(c);
    if (c == CH_ZERO) begin
      scan.ended = 1'b1;
      scan.phase = P_DONE;
      return;
    end
    if (scan.pos >= MAX_PATH_CHARS) scan.saturated = 1'b1;
    else scan.pos = scan.pos + 1'b1;
  endfunction

  function automatic void predict_prefix(logic [CH_W-1:0] c, logic last);
    prefix_result_t r;
    scan_char(c);
    if (!last) return;
    scan_char(CH_ZERO);
    r.kind     = scan.kind;
    r.len      = scan.plen;
    r.rooted   = scan.rooted;
    r.absolute = (scan.plen != 0) && scan.rooted;
    r.overflow = scan.saturated;
    pending_prefixes.push_back(r);
    clear_scan();
  endfunction

  // ---------------------------------------------------------------------------
  // Path generation
  // ---------------------------------------------------------------------------

  function automatic char_q_t chars_of(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back({8'h00, s[i]});
    return q;
  endfunction

  function automatic logic [CH_W-1:0] rand_letter();
    if ($urandom_range(0, 1)) return CH_UA + $urandom_range(0, 25);
    return CH_LA + $urandom_range(0, 25);
  endfunction

  // Nonzero unit, weighted toward the characters that steer the grammar
  function automatic logic [CH_W-1:0] rand_char();
    logic [CH_W-1:0] c;
    case ($urandom_range(0, 11))
      0:       c = CH_BSLASH;
      1:       c = CH_COLON;
      2:       c = CH_DOT;
      3:       c = CH_QMARK;
      4:       c = CH_U;
      5:       c = CH_N;
      6:       c = CH_C;
      7, 8:    c = rand_letter();
      9: begin
        case ($urandom_range(0, 4))
          0:       c = CH_UA - 1'b1;
          1:       c = CH_UZ + 1'b1;
          2:       c = CH_LA - 1'b1;
          3:       c = CH_LZ + 1'b1;
          default: c = 16'hFFFF;
        endcase
      end
      default: c = $urandom_range(1, 65535);
    endcase
    return c;
  endfunction

  function automatic void add_name(ref char_q_t p);
    logic [CH_W-1:0] c;
    repeat ($urandom_range(0, 3)) begin
      do c = rand_char(); while (c == CH_BSLASH);
      p.push_back(c);
    end
  endfunction

  // Mostly well-formed prefixes with random names and tails, some broken or noise
  function automatic char_q_t random_path();
    char_q_t     p;
    int unsigned cut;
    case ($urandom_range(0, 9))
      0: begin
        p.push_back(rand_letter());
        p.push_back(CH_COLON);
        if ($urandom_range(0, 1)) p.push_back(CH_BSLASH);
      end
      1: begin
        p = chars_of("\\\\.\\");
        add_name(p);
      end
      2: p = chars_of("\\\\?\\");
      3: begin
        p = chars_of("\\\\?\\");
        p.push_back($urandom_range(0, 1) ? CH_U : rand_letter());
        p.push_back(CH_COLON);
      end
      4: begin
        p = chars_of("\\\\?\\UNC\\");
        add_name(p);
        p.push_back(CH_BSLASH);
        add_name(p);
      end
      5, 6: begin
        p = chars_of("\\\\");
        add_name(p);
        p.push_back(CH_BSLASH);
        add_name(p);
      end
      7: p.push_back(CH_BSLASH);
      default: ;
    endcase
    // Break the prefix now and then
    if (p.size() > 1 && $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, p.size() - 1);
      p = p[0:cut-1];
    end
    repeat ($urandom_range(0, 6)) p.push_back(rand_char());
    if ($urandom_range(0, 9) == 0) begin
      p.push_back(CH_ZERO);
      repeat ($urandom_range(0, 3)) p.push_back($urandom_range(0, 65535));
    end
    if (p.size() == 0) p.push_back(CH_ZERO);
    return p;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  task automatic send_char(logic [CH_W-1:0] c, logic last);
    int unsigned g;
    in_if.valid <= 1'b1;
    in_if.ch    <= c;
    in_if.last  <= last;
    do @(posedge clk); while (!in_if.ready);
    predict_prefix(c, last);
    chars_sent++;
    g = gap_len();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_path(char_q_t p);
    for (int i = 0; i < p.size(); i++) send_char(p[i], i == p.size() - 1);
  endtask

  // Hold the input until every predicted result is back, then let the block settle
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (pending_prefixes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_prefix_kinds();
    send_path(chars_of("A:\\d"));
    send_path(chars_of("z:"));
    send_path(chars_of("\\\\.\\COM1\\x"));
    send_path(chars_of("\\\\?\\"));
    send_path(chars_of("\\\\?\\Q:\\"));
    send_path(chars_of("\\\\?\\UNC\\s\\h"));
    send_path(chars_of("\\\\sv\\sh\\f"));
  endtask

  task automatic test_corner_paths();
    char_q_t p;
    // Empty share, empty device name, empty verbatim server
    send_path(chars_of("\\\\sv"));
    send_path(chars_of("\\\\.\\\\"));
    send_path(chars_of("\\\\?\\UNC\\\\s"));
    // Empty path
    p = {CH_ZERO};
    send_path(p);
    // Units after the terminator, all-ones unit
    p = {CH_BSLASH, CH_ZERO, 16'hFFFF, CH_BSLASH};
    send_path(p);
    p = {16'hFFFF};
    send_path(p);
    wait_for_results();
  endtask

  // Share names that run to the counter limit and past it
  task automatic test_path_overflow();
    char_q_t     p;
    int unsigned lens[3] = '{MAX_PATH_CHARS, MAX_PATH_CHARS + 1, MAX_PATH_CHARS + 5};
    idle_enabled = 1'b0;
    foreach (lens[i]) begin
      p = chars_of("\\\\s\\");
      while (p.size() < lens[i]) p.push_back(rand_letter());
      send_path(p);
    end
    // Terminator just before the limit; later units must not saturate
    p = chars_of("\\\\s\\");
    while (p.size() < MAX_PATH_CHARS - 1) p.push_back(rand_letter());
    p.push_back(CH_ZERO);
    repeat (10) p.push_back(rand_char());
    send_path(p);
    idle_enabled = 1'b1;
    wait_for_results();
  endtask

  // Hold off the results while the sender keeps pushing, then drain fully
  task automatic test_result_backpressure();
    idle_enabled  = 1'b0;
    long_hold_req = 1'b1;
    repeat (30) send_path(random_path());
    idle_enabled = 1'b1;
    wait_for_results();
  endtask

  task automatic test_random_paths();
    int unsigned start_count;
    int unsigned paths;
    start_count = chars_sent;
    paths       = 0;
    while (chars_sent - start_count < RANDOM_CHARS) begin
      if (paths % 40 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      send_path(random_path());
      paths++;
      if ($urandom_range(0, 99) == 0) wait_for_results();
    end
    idle_enabled = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Drive result ready: random stalls, plus one long hold on request
  initial begin : result_sink
    int unsigned n;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_if.ready <= 1'b0;
        n = LONG_HOLD;
      end else begin
        n = gap_len();
        out_if.ready <= (n == 0);
      end
      repeat (n) @(posedge clk);
    end
  end

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    prefix_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_prefixes.size() == 0) begin
        $error("result transaction with no prediction pending");
        fail_count++;
      end else begin
        want = pending_prefixes.pop_front();
        compare_field("prefix_kind", want.kind,     out_if.prefix_kind);
        compare_field("prefix_len",  want.len,      out_if.prefix_len);
        compare_field("rooted",      want.rooted,   out_if.rooted);
        compare_field("absolute",    want.absolute, out_if.absolute);
        compare_field("overflow",    want.overflow, out_if.overflow);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    in_if.valid = 1'b0;
    in_if.ch    = '0;
    in_if.last  = 1'b0;
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    test_prefix_kinds();
    test_corner_paths();
    test_path_overflow();
    test_result_backpressure();
    test_random_paths();
    wait_for_results();

    if (pending_prefixes.size() != 0) begin
      $error("%0d predicted results never arrived", pending_prefixes.size());
      fail_count++;
    end
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
